/* rtl/svct_pkg.sv */
// Shared types and constants for the sorted value count table.
package svct_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int NUM_W       = ADDR_W + 1;
    localparam int KEY_W       = 32;
    localparam int AMOUNT_W    = 32;
    localparam int COUNT_W     = 48;

    localparam logic [1:0] ST_ADDED    = 2'd0;
    localparam logic [1:0] ST_INSERTED = 2'd1;
    localparam logic [1:0] ST_DROPPED  = 2'd2;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [AMOUNT_W-1:0]     amount;
    } sample_t;

    typedef struct packed {
        logic [1:0]              status;
        logic [7:0]              position;
        logic [COUNT_W-1:0]      entry_count;
        logic [8:0]              unique_entries;
        logic [COUNT_W-1:0]      total_samples;
        logic signed [KEY_W-1:0] min_key;
        logic signed [KEY_W-1:0] max_key;
    } result_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [COUNT_W-1:0]      count;
    } entry_t;

    typedef struct packed {
        logic load;
        logic srch_rd;
        logic srch_step;
        logic chk_rd;
        logic upd;
        logic drop;
        logic sh_init;
        logic sh_rd;
        logic sh_wr;
        logic ins;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic srch_done;
        logic hit;
        logic full;
        logic sh_none;
        logic out_free;
    } stat_t;

endpackage

/* rtl/svct_ctrl.sv */
// Sequencing state machine for the sorted value count table.
module svct_ctrl
    import svct_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  sample_valid,
    output logic  sample_stall,
    input  stat_t stat,
    output cmd_t  cmd
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SRCH  = 4'd1;
    localparam logic [3:0] S_SCMP  = 4'd2;
    localparam logic [3:0] S_CHKR  = 4'd3;
    localparam logic [3:0] S_CHK   = 4'd4;
    localparam logic [3:0] S_SHIFT = 4'd5;
    localparam logic [3:0] S_SHWR  = 4'd6;
    localparam logic [3:0] S_INS   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    assign sample_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SRCH;
                end
            end
            S_SRCH:
            begin
                if (stat.srch_done)
                begin
                    state_next = S_CHKR;
                end
                else
                begin
                    cmd.srch_rd = 1'b1;
                    state_next  = S_SCMP;
                end
            end
            S_SCMP:
            begin
                cmd.srch_step = 1'b1;
                state_next    = S_SRCH;
            end
            S_CHKR:
            begin
                cmd.chk_rd = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (stat.hit)
                begin
                    cmd.upd    = 1'b1;
                    state_next = S_DONE;
                end
                else if (stat.full)
                begin
                    cmd.drop   = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.sh_init = 1'b1;
                    state_next  = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                if (stat.sh_none)
                begin
                    state_next = S_INS;
                end
                else
                begin
                    cmd.sh_rd  = 1'b1;
                    state_next = S_SHWR;
                end
            end
            S_SHWR:
            begin
                cmd.sh_wr  = 1'b1;
                state_next = S_SHIFT;
            end
            S_INS:
            begin
                cmd.ins    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/svct_dp.sv */
// Datapath of the sorted value count table: entry memory, search bounds and totals.
module svct_dp
    import svct_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  sample_t sample,
    input  cmd_t    cmd,
    output stat_t   stat,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    localparam logic [NUM_W-1:0] DEPTH_N = NUM_W'(TABLE_DEPTH);

    entry_t mem [TABLE_DEPTH];
    entry_t rd_reg;

    logic signed [KEY_W-1:0] key_reg;
    logic [AMOUNT_W-1:0]     amount_reg;
    logic [NUM_W-1:0]        lo_reg, lo_next;
    logic [NUM_W-1:0]        hi_reg, hi_next;
    logic [NUM_W-1:0]        idx_reg;
    logic [NUM_W-1:0]        used_reg;
    logic [COUNT_W-1:0]      total_reg;
    logic signed [KEY_W-1:0] min_reg, max_reg;
    logic [1:0]              status_reg;
    logic [COUNT_W-1:0]      cnt_reg;
    logic                    out_valid_reg;
    result_t                 out_reg;

    logic [NUM_W:0]       mid_sum;
    logic [ADDR_W-1:0]    mid;
    logic [NUM_W-1:0]     idx_dec;
    logic [ADDR_W-1:0]    raddr;
    logic                 we;
    logic [ADDR_W-1:0]    waddr;
    entry_t               wdata;
    logic [COUNT_W:0]     cnt_sum;
    logic [COUNT_W-1:0]   cnt_sat;
    logic [COUNT_W:0]     tot_sum;
    logic [COUNT_W-1:0]   tot_sat;

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[ADDR_W:1];
    assign idx_dec = idx_reg - NUM_W'(1);

    assign cnt_sum = {1'b0, rd_reg.count} + (COUNT_W+1)'(amount_reg);
    assign cnt_sat = cnt_sum[COUNT_W] ? '1 : cnt_sum[COUNT_W-1:0];
    assign tot_sum = {1'b0, total_reg} + (COUNT_W+1)'(amount_reg);
    assign tot_sat = tot_sum[COUNT_W] ? '1 : tot_sum[COUNT_W-1:0];

    assign stat.srch_done = (lo_reg == hi_reg);
    assign stat.hit       = (lo_reg < used_reg) && (rd_reg.key == key_reg);
    assign stat.full      = (used_reg == DEPTH_N);
    assign stat.sh_none   = (idx_reg == lo_reg);
    assign stat.out_free  = !out_valid_reg || !result_stall;

    always_comb
    begin
        if (cmd.srch_rd)
        begin
            raddr = mid;
        end
        else if (cmd.chk_rd)
        begin
            raddr = lo_reg[ADDR_W-1:0];
        end
        else if (cmd.sh_rd)
        begin
            raddr = idx_dec[ADDR_W-1:0];
        end
        else
        begin
            raddr = lo_reg[ADDR_W-1:0];
        end

        we    = cmd.upd || cmd.sh_wr || cmd.ins;
        waddr = lo_reg[ADDR_W-1:0];
        wdata = '{key: key_reg, count: cnt_sat};
        if (cmd.sh_wr)
        begin
            waddr = idx_reg[ADDR_W-1:0];
            wdata = rd_reg;
        end
        else if (cmd.ins)
        begin
            wdata = '{key: key_reg, count: COUNT_W'(amount_reg)};
        end

        lo_next = lo_reg;
        hi_next = hi_reg;
        if (rd_reg.key < key_reg)
        begin
            lo_next = {1'b0, mid} + NUM_W'(1);
        end
        else
        begin
            hi_next = {1'b0, mid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    // Item payload and working registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg    <= sample.key;
            amount_reg <= sample.amount;
            lo_reg     <= '0;
            hi_reg     <= used_reg;
        end
        else if (cmd.srch_step)
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
        if (cmd.sh_init)
        begin
            idx_reg <= used_reg;
        end
        else if (cmd.sh_wr)
        begin
            idx_reg <= idx_dec;
        end
        if (cmd.upd)
        begin
            status_reg <= ST_ADDED;
            cnt_reg    <= cnt_sat;
        end
        else if (cmd.drop)
        begin
            status_reg <= ST_DROPPED;
            cnt_reg    <= '0;
        end
        else if (cmd.ins)
        begin
            status_reg <= ST_INSERTED;
            cnt_reg    <= COUNT_W'(amount_reg);
        end
        if (cmd.emit)
        begin
            out_reg.status         <= status_reg;
            out_reg.position       <= (status_reg == ST_DROPPED) ? 8'd0 : lo_reg[7:0];
            out_reg.entry_count    <= cnt_reg;
            out_reg.unique_entries <= 9'(used_reg);
            out_reg.total_samples  <= total_reg;
            out_reg.min_key        <= min_reg;
            out_reg.max_key        <= max_reg;
        end
    end

    // Table-wide state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            total_reg     <= '0;
            min_reg       <= '0;
            max_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.upd)
            begin
                total_reg <= tot_sat;
            end
            if (cmd.ins)
            begin
                total_reg <= tot_sat;
                used_reg  <= used_reg + NUM_W'(1);
                if (lo_reg == '0)
                begin
                    min_reg <= key_reg;
                end
                if (lo_reg == used_reg)
                begin
                    max_reg <= key_reg;
                end
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

/* rtl/sorted_value_count_table_top.sv */
// Top level of the sorted value count table.
//
//   channel   direction   handshake              payload
//   sample    in          sample_valid/stall     sample_t (key, amount)
//   result    out         result_valid/stall     result_t (status .. max_key)
//
// An accepted item is found by a binary search of k steps, k at most ceil(log2(n+1)),
// over the n keys held; a key already held has its count updated, and a full table
// drops the item. An insertion moves every entry above the new key up one place,
// from the top down, and then writes the new entry. The next item is taken in the
// cycle after the result is loaded.
// Reset empties the table at once: the count of held keys and the total return to
// zero, and the memory needs no clearing.
// A stalled result waits in the output register; the next item is taken meanwhile and
// its result waits in the working registers of the datapath until the register is free.
module sorted_value_count_table_top
    import svct_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    sample_valid,
    output logic    sample_stall,
    input  sample_t sample,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    cmd_t  cmd;
    stat_t stat;

    // The controller walks the binary search, the shift and the write-back.
    svct_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .stat         (stat),
        .cmd          (cmd)
    );

    // The datapath holds the sorted entries, the totals and the output register.
    svct_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample       (sample),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

/* rtl/svct_checker.sv */
// Port-level checks for the sorted value count table, bound to the top level.
module svct_checker
    import svct_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    sample_valid,
    input logic    sample_stall,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("stalled result changed");

    a_drop: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == ST_DROPPED |->
        result.position == 8'd0 && result.entry_count == '0 &&
        result.unique_entries == 9'(TABLE_DEPTH))
        else $error("dropped item reported wrongly");

    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.status <= ST_DROPPED && result.unique_entries != 9'd0)
        else $error("bad status or empty table in result");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.min_key <= result.max_key)
        else $error("minimum key above maximum key");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_stall |=> sample_stall)
        else $error("input not held off while an item is in work");

endmodule

bind sorted_value_count_table_top svct_checker u_svct_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
